>>> design/gekf_pkg.sv
// Shared types, constants and helper functions of the gyro/encoder fusion core.
package gekf_pkg;

   // Calibration length used when the top level is not given one.
   localparam int unsigned BIAS_SAMPLES_DEF = 1000;

   // Shared multiplier: signed A by signed B, full product.
   localparam int unsigned MUL_AW = 34;
   localparam int unsigned MUL_BW = 26;
   localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

   // Shared shift-subtract divider.
   localparam int unsigned DIV_NW = 43;
   localparam int unsigned DIV_DW = 32;
   localparam int unsigned DIV_CW = 6;
   localparam logic [DIV_CW-1:0] DIV_ITERS_BIAS = DIV_CW'(DIV_NW);
   localparam logic [DIV_CW-1:0] DIV_ITERS_GAIN = DIV_CW'(25);

   localparam int unsigned GAIN_BITS = 24;
   localparam int unsigned GAIN_W    = GAIN_BITS + 1;
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

   localparam int unsigned CSR_IW = 3;

   localparam logic [16:0] TIME_STEP_RST     = 17'd66;
   localparam logic [30:0] PROCESS_NOISE_RST = 31'd66;
   localparam logic [30:0] ENCODER_NOISE_RST = 31'd65536;
   localparam logic [15:0] GYRO_SCALE_RST    = 16'd1998;
   localparam logic [15:0] ENCODER_SCALE_RST = 16'd11796;
   localparam logic [30:0] INIT_VAR_RST      = 31'd65536;

   localparam logic [32:0] DEG180 = 33'd180 << 16;
   localparam logic [32:0] DEG360 = 33'd360 << 16;

   localparam logic signed [63:0] INT32_MAX_64 = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] INT32_MIN_64 = 64'shFFFF_FFFF_8000_0000;
   localparam logic [30:0] VAR_MAX = 31'h7FFF_FFFF;

   typedef enum logic [CSR_IW-1:0] {
      REG_TIME_STEP     = 3'd0,
      REG_PROCESS_NOISE = 3'd1,
      REG_ENCODER_NOISE = 3'd2,
      REG_GYRO_SCALE    = 3'd3,
      REG_ENCODER_SCALE = 3'd4,
      REG_INIT_VARIANCE = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_BEGIN = 2'd0,
      PH_CAL   = 2'd1,
      PH_RUN   = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_RATE,
      S_MUL_POS,
      S_PHASE,
      S_BIAS_WAIT,
      S_MUL_PRED,
      S_PRED,
      S_GAIN_WAIT,
      S_MUL_CORR,
      S_CORR,
      S_VAR,
      S_EMIT
   } seq_state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_CW-1:0] iters;
      logic [DIV_DW-1:0] rem_init;
      logic [DIV_NW-1:0] num_low;
      logic [DIV_DW-1:0] den;
   } div_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > INT32_MAX_64) begin
         return 32'sh7FFF_FFFF;
      end else if (v < INT32_MIN_64) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Divide by 2^sh, rounding to nearest with ties away from zero. A negative
   // value gets one less than half added before the arithmetic shift.
   function automatic logic signed [MUL_PW-1:0] round_shift(
      input logic signed [MUL_PW-1:0] v,
      input int unsigned              sh
   );
      logic signed [MUL_PW:0] half;
      logic signed [MUL_PW:0] t;
      half = $signed((MUL_PW+1)'(1) << (sh - 1));
      t = (MUL_PW+1)'(v) + half - $signed((MUL_PW+1)'(v[MUL_PW-1]));
      return MUL_PW'(t >>> sh);
   endfunction

endpackage

>>> design/gekf_mul.sv
// Shared signed multiplier with a registered product.
module gekf_mul (
   input  logic                                clock,
   input  logic signed [gekf_pkg::MUL_AW-1:0]  a,
   input  logic signed [gekf_pkg::MUL_BW-1:0]  b,
   output logic signed [gekf_pkg::MUL_PW-1:0]  prod
);
   import gekf_pkg::*;

   logic signed [MUL_PW-1:0] prod_ff;
   logic signed [MUL_PW-1:0] prod_in;

   assign prod_in = MUL_PW'(a) * MUL_PW'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> design/gekf_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
module gekf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  gekf_pkg::div_req_type         req,
   output logic                          done,
   output logic [gekf_pkg::DIV_NW-1:0]   quot
);
   import gekf_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] count_ff, count_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] sh_ff, sh_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;
   logic              fits;

   always_comb begin
      trial = {rem_ff, sh_ff[DIV_NW-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      den_in   = den_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = req.iters;
         rem_in   = req.rem_init;
         sh_in    = req.num_low;
         den_in   = req.den;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so its top bit drops out.
         rem_in   = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
         sh_in    = {sh_ff[DIV_NW-2:0], fits};
         count_in = count_ff - DIV_CW'(1);
         if (count_ff == DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = sh_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still iterating");
`endif

endmodule

>>> design/gyro_encoder_kalman_fusion_core.sv
// Gyro/encoder angle fusion core: sequencer, state and datapath around the shared units.
//
// Usage: input items arrive on req_* (valid/ready), results leave on rsp_* (valid/ready),
// and the six settings registers are written on csr_* (index, data), which is always ready
// and should be written only while the core is idle.
// The first item after reset loads the initial variance and starts calibration. The next
// BIAS_SAMPLES items sum the gyro rate; the item after them averages the sum into a bias
// on the shared divider. None of these give a result. Every later item gives one result.
// An item whose encoder angle did not change skips the Kalman update; one that runs it
// divides for the 25-bit gain on the shared divider unless the denominator is zero, and
// makes more passes through the shared multiplier.
// One item is in work at a time: req_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next item is taken while it waits; if the
// receiver still stalls when the following result is done, the sequencer holds until the
// transfer. Reset clears the filter state, the phase and the counters, loads the register
// defaults, and drops rsp_valid.
module gyro_encoder_kalman_fusion_core #(
   parameter int unsigned BIAS_SAMPLES = gekf_pkg::BIAS_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [15:0]            req_gyro_raw,
   input  logic                          req_gyro_ok,
   input  logic [15:0]                   req_encoder_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_step_number,
   output logic signed [31:0]            rsp_measured_position,
   output logic signed [31:0]            rsp_gyro_rate,
   output logic signed [31:0]            rsp_filtered_position,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gekf_pkg::CSR_IW-1:0]   csr_index,
   input  logic [31:0]                   csr_data
);
   import gekf_pkg::*;

   localparam int unsigned CNT_W  = $clog2(BIAS_SAMPLES + 1);
   localparam int unsigned SUM_W  = 32 + CNT_W;
   localparam int unsigned HALF_B = BIAS_SAMPLES / 2;

   // Settings registers.
   logic [16:0] time_step_ff;
   logic [30:0] process_noise_ff;
   logic [30:0] encoder_noise_ff;
   logic [15:0] gyro_scale_ff;
   logic [15:0] encoder_scale_ff;
   logic [30:0] init_var_ff;

   // Control and filter state.
   seq_state_type            state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic signed [SUM_W-1:0]  bias_sum_ff, bias_sum_in;
   logic [CNT_W-1:0]         sample_count_ff, sample_count_in;
   logic [31:0]              step_counter_ff, step_counter_in;
   logic signed [31:0]       prev_pos_ff, prev_pos_in;
   logic signed [31:0]       estimate_ff, estimate_in;
   logic [30:0]              variance_ff, variance_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Item and work registers.
   logic signed [15:0]       raw_ff, raw_in;
   logic                     ok_ff, ok_in;
   logic [15:0]              cnt_ff, cnt_in;
   logic signed [31:0]       rate_ff, rate_in;
   logic signed [31:0]       pos_ff, pos_in;
   logic signed [31:0]       rate_c_ff, rate_c_in;
   logic [30:0]              pm_ff, pm_in;
   logic signed [31:0]       pred_ff, pred_in;
   logic signed [32:0]       err_ff, err_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;

   // Result registers.
   logic [31:0]              out_step_ff, out_step_in;
   logic signed [31:0]       out_pos_ff, out_pos_in;
   logic signed [31:0]       out_rate_ff, out_rate_in;
   logic signed [31:0]       out_est_ff, out_est_in;

   // Shared units.
   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [MUL_PW-1:0] prod;
   div_req_type              div_req;
   logic                     div_done;
   logic [DIV_NW-1:0]        div_quot;

   // Combinational helpers.
   logic [32:0]              pos_u;
   logic signed [33:0]       pos_w;
   logic signed [31:0]       pos_sat;
   logic [SUM_W-1:0]         bias_mag;
   logic [DIV_NW-1:0]        bias_num;
   logic [31:0]              pm_sum;
   logic [31:0]              den;
   logic [55:0]              gain_num;
   logic signed [31:0]       pred_val;
   logic signed [MUL_PW-1:0] var_round;

   gekf_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   gekf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff     <= TIME_STEP_RST;
         process_noise_ff <= PROCESS_NOISE_RST;
         encoder_noise_ff <= ENCODER_NOISE_RST;
         gyro_scale_ff    <= GYRO_SCALE_RST;
         encoder_scale_ff <= ENCODER_SCALE_RST;
         init_var_ff      <= INIT_VAR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TIME_STEP:     time_step_ff     <= csr_data[16:0];
            REG_PROCESS_NOISE: process_noise_ff <= csr_data[30:0];
            REG_ENCODER_NOISE: encoder_noise_ff <= csr_data[30:0];
            REG_GYRO_SCALE:    gyro_scale_ff    <= csr_data[15:0];
            REG_ENCODER_SCALE: encoder_scale_ff <= csr_data[15:0];
            REG_INIT_VARIANCE: init_var_ff      <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_RATE: begin
            mul_a = {{(MUL_AW-16){raw_ff[15]}}, raw_ff};
            mul_b = ok_ff ? {{(MUL_BW-16){1'b0}}, gyro_scale_ff} : '0;
         end
         S_MUL_POS: begin
            mul_a = {{(MUL_AW-16){1'b0}}, cnt_ff};
            mul_b = {{(MUL_BW-16){1'b0}}, encoder_scale_ff};
         end
         S_MUL_PRED: begin
            mul_a = {{(MUL_AW-32){rate_c_ff[31]}}, rate_c_ff};
            mul_b = {{(MUL_BW-17){1'b0}}, time_step_ff};
         end
         S_MUL_CORR: begin
            mul_a = {{(MUL_AW-33){err_ff[32]}}, err_ff};
            mul_b = {{(MUL_BW-GAIN_W){1'b0}}, gain_ff};
         end
         S_CORR: begin
            mul_a = {{(MUL_AW-31){1'b0}}, pm_ff};
            mul_b = {{(MUL_BW-GAIN_W){1'b0}}, GAIN_ONE - gain_ff};
         end
         default: ;
      endcase
   end

   // Datapath helpers.
   always_comb begin
      // Angles in the upper half turn wrap to negative degrees.
      pos_u = prod[32:0];
      if ((pos_u > DEG180) && (pos_u <= DEG360)) begin
         pos_w = $signed({1'b0, pos_u}) - $signed({1'b0, DEG360});
      end else begin
         pos_w = $signed({1'b0, pos_u});
      end
      pos_sat  = sat32(64'(pos_w));
      bias_mag = bias_sum_ff[SUM_W-1] ? SUM_W'(-bias_sum_ff) : SUM_W'(bias_sum_ff);
      bias_num = DIV_NW'(bias_mag) + DIV_NW'(HALF_B);
      pm_sum   = {1'b0, variance_ff} + {1'b0, process_noise_ff};
      den      = {1'b0, pm_ff} + {1'b0, encoder_noise_ff};
      gain_num = {1'b0, pm_ff, 24'b0} + 56'(den >> 1);
      pred_val = sat32(64'(estimate_ff) + 64'(round_shift(prod, 16)));
      var_round = round_shift(prod, GAIN_BITS);
   end

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      bias_sum_in     = bias_sum_ff;
      sample_count_in = sample_count_ff;
      step_counter_in = step_counter_ff;
      prev_pos_in     = prev_pos_ff;
      estimate_in     = estimate_ff;
      variance_in     = variance_ff;
      raw_in          = raw_ff;
      ok_in           = ok_ff;
      cnt_in          = cnt_ff;
      rate_in         = rate_ff;
      pos_in          = pos_ff;
      rate_c_in       = rate_c_ff;
      pm_in           = pm_ff;
      pred_in         = pred_ff;
      err_in          = err_ff;
      gain_in         = gain_ff;
      out_step_in     = out_step_ff;
      out_pos_in      = out_pos_ff;
      out_rate_in     = out_rate_ff;
      out_est_in      = out_est_ff;
      req_ready       = 1'b0;
      div_req         = '0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               raw_in   = req_gyro_raw;
               ok_in    = req_gyro_ok;
               cnt_in   = req_encoder_count;
               state_in = S_MUL_RATE;
            end
         end
         S_MUL_RATE: begin
            state_in = S_MUL_POS;
         end
         S_MUL_POS: begin
            rate_in  = prod[31:0];
            state_in = S_PHASE;
         end
         S_PHASE: begin
            case (phase_ff)
               PH_BEGIN: begin
                  phase_in    = PH_CAL;
                  variance_in = init_var_ff;
                  state_in    = S_IDLE;
               end
               PH_CAL: begin
                  if (sample_count_ff < CNT_W'(BIAS_SAMPLES)) begin
                     bias_sum_in     = bias_sum_ff + SUM_W'(rate_ff);
                     sample_count_in = sample_count_ff + CNT_W'(1);
                     state_in        = S_IDLE;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.iters    = DIV_ITERS_BIAS;
                     div_req.rem_init = '0;
                     div_req.num_low  = bias_num;
                     div_req.den      = DIV_DW'(BIAS_SAMPLES);
                     state_in         = S_BIAS_WAIT;
                  end
               end
               PH_RUN: begin
                  step_counter_in = step_counter_ff + 32'd1;
                  rate_c_in = sat32(64'(rate_ff) - 64'(bias_sum_ff));
                  pos_in    = pos_sat;
                  pm_in     = pm_sum[31] ? VAR_MAX : pm_sum[30:0];
                  state_in  = S_MUL_PRED;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_BIAS_WAIT: begin
            if (div_done) begin
               // The sum register now holds the rounded mean, sign restored.
               if (bias_sum_ff[SUM_W-1]) begin
                  bias_sum_in = -$signed(SUM_W'(div_quot));
               end else begin
                  bias_sum_in = $signed(SUM_W'(div_quot));
               end
               phase_in = PH_RUN;
               state_in = S_IDLE;
            end
         end
         S_MUL_PRED: begin
            state_in = S_PRED;
         end
         S_PRED: begin
            pred_in = pred_val;
            if (pos_ff == prev_pos_ff) begin
               estimate_in = pred_val;
               variance_in = pm_ff;
               state_in    = S_EMIT;
            end else begin
               err_in = 33'(pos_ff) - 33'(pred_val);
               if (den == 32'd0) begin
                  gain_in  = '0;
                  state_in = S_MUL_CORR;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.iters    = DIV_ITERS_GAIN;
                  div_req.rem_init = DIV_DW'(gain_num[55:GAIN_W]);
                  div_req.num_low  = {gain_num[GAIN_W-1:0], {(DIV_NW-GAIN_W){1'b0}}};
                  div_req.den      = den;
                  state_in         = S_GAIN_WAIT;
               end
            end
         end
         S_GAIN_WAIT: begin
            if (div_done) begin
               gain_in  = div_quot[GAIN_W-1:0];
               state_in = S_MUL_CORR;
            end
         end
         S_MUL_CORR: begin
            state_in = S_CORR;
         end
         S_CORR: begin
            estimate_in = sat32(64'(pred_ff) + 64'(round_shift(prod, GAIN_BITS)));
            state_in    = S_VAR;
         end
         S_VAR: begin
            if (var_round[MUL_PW-1:31] != '0) begin
               variance_in = VAR_MAX;
            end else begin
               variance_in = var_round[30:0];
            end
            prev_pos_in = pos_ff;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            prev_pos_in = pos_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               out_step_in  = step_counter_ff;
               out_pos_in   = pos_ff;
               out_rate_in  = rate_c_ff;
               out_est_in   = estimate_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         phase_ff        <= PH_BEGIN;
         bias_sum_ff     <= '0;
         sample_count_ff <= '0;
         step_counter_ff <= '0;
         prev_pos_ff     <= '0;
         estimate_ff     <= '0;
         variance_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         bias_sum_ff     <= bias_sum_in;
         sample_count_ff <= sample_count_in;
         step_counter_ff <= step_counter_in;
         prev_pos_ff     <= prev_pos_in;
         estimate_ff     <= estimate_in;
         variance_ff     <= variance_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      ok_ff       <= ok_in;
      cnt_ff      <= cnt_in;
      rate_ff     <= rate_in;
      pos_ff      <= pos_in;
      rate_c_ff   <= rate_c_in;
      pm_ff       <= pm_in;
      pred_ff     <= pred_in;
      err_ff      <= err_in;
      gain_ff     <= gain_in;
      out_step_ff <= out_step_in;
      out_pos_ff  <= out_pos_in;
      out_rate_ff <= out_rate_in;
      out_est_ff  <= out_est_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_step_number       = out_step_ff;
   assign rsp_measured_position = out_pos_ff;
   assign rsp_gyro_rate         = out_rate_ff;
   assign rsp_filtered_position = out_est_ff;

`ifndef SYNTHESIS
   a_no_stop: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_STOP)
      else $error("core entered the stopped phase");
   a_cal_bound: assert property (@(posedge clock) disable iff (reset)
      sample_count_ff <= CNT_W'(BIAS_SAMPLES))
      else $error("calibration sample count overran");
   a_step_match: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_step_number == step_counter_ff))
      else $error("result step number differs from step counter");
   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MUL_RATE))
      else $error("accepted item did not start the sequence");
`endif

endmodule
